[design/bldc_pkg.sv]
// bldc_pkg: shared types, constants and codes for the battery load disconnect controller
`default_nettype none

package bldc_pkg;

    localparam int SAMPLES_PER_GROUP = 64;
    localparam int SAMPLE_BITS       = 12;

    localparam int LIGHT_W = 12;
    localparam int SUM_W   = 18;
    localparam int TICK_W  = 22;
    localparam int CFG_W   = 22;
    localparam int IDX_W   = 3;
    localparam int EVT_W   = 2;

    localparam int ACC_W = SAMPLE_BITS + $clog2(SAMPLES_PER_GROUP) + 1;
    localparam int CNT_W = $clog2(SAMPLES_PER_GROUP + 1);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_GROUP - 1);
    localparam logic [SUM_W-1:0] SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    // register indexes
    localparam logic [IDX_W-1:0] CFG_CRITICAL_SUM    = 3'd0;
    localparam logic [IDX_W-1:0] CFG_RECOVERY_SUM    = 3'd1;
    localparam logic [IDX_W-1:0] CFG_DAYLIGHT_LEVEL  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_COOLDOWN_TICKS  = 3'd3;
    localparam logic [IDX_W-1:0] CFG_REPORT_INTERVAL = 3'd4;

    localparam logic [SUM_W-1:0]   CRITICAL_SUM_RST    = 18'd181155;
    localparam logic [SUM_W-1:0]   RECOVERY_SUM_RST    = 18'd189850;
    localparam logic [LIGHT_W-1:0] DAYLIGHT_LEVEL_RST  = 12'd1000;
    localparam logic [TICK_W-1:0]  COOLDOWN_TICKS_RST  = 22'd300000;
    localparam logic [TICK_W-1:0]  REPORT_INTERVAL_RST = 22'd300000;

    // switch event codes
    localparam logic [EVT_W-1:0] SW_NONE    = 2'd0;
    localparam logic [EVT_W-1:0] SW_OFF     = 2'd1;
    localparam logic [EVT_W-1:0] SW_ON      = 2'd2;
    localparam logic [EVT_W-1:0] SW_BLOCKED = 2'd3;

    // report event codes
    localparam logic [EVT_W-1:0] REP_NONE    = 2'd0;
    localparam logic [EVT_W-1:0] REP_DUE     = 2'd1;
    localparam logic [EVT_W-1:0] REP_SKIPPED = 2'd2;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] battery_sample;
        logic [LIGHT_W-1:0]     light_sample;
    } in_item_t;

    typedef struct packed {
        logic             load_enable;
        logic             evaluated;
        logic [SUM_W-1:0] battery_total;
        logic [EVT_W-1:0] switch_event;
        logic [EVT_W-1:0] report_event;
    } out_item_t;

endpackage

`default_nettype wire

[design/battery_load_disconnect_controller_top.sv]
// battery_load_disconnect_controller_top: low-voltage load disconnect with hysteresis
//
// One sample pair is taken per transfer and every transfer yields exactly one result, which
// appears in the output register on the cycle after the input transfer. A new item may be
// transferred in every cycle: the accumulator, sample counter, load state and both tick timers
// are all updated together on each transfer, and the input side stalls only while a result is held
// in the output register against a stalled receiver. Battery samples are summed over groups
// of SAMPLES_PER_GROUP transfers; at each group end the sum is checked against the critical
// and recovery thresholds and the light level, a load change is applied once more than
// cooldown_ticks transfers have passed since the previous change (otherwise flagged as
// blocked), and a telemetry report is flagged when the report interval has elapsed.
// The load is on after reset. Configuration writes should be made while the block is idle.
`default_nettype none

module battery_load_disconnect_controller_top
    import bldc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,

    input  wire logic             cfg_write,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,

    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire in_item_t         in_data,

    output logic                  out_valid,
    input  wire logic             out_stall,
    output out_item_t             out_data
);

    logic [SUM_W-1:0]   critical_sum_reg;
    logic [SUM_W-1:0]   recovery_sum_reg;
    logic [LIGHT_W-1:0] daylight_level_reg;
    logic [TICK_W-1:0]  cooldown_ticks_reg;
    logic [TICK_W-1:0]  report_interval_reg;

    logic [ACC_W-1:0]   acc_reg,        acc_next;
    logic [CNT_W-1:0]   cnt_reg,        cnt_next;
    logic               load_on_reg,    load_on_next;
    logic [TICK_W-1:0]  since_chg_reg,  since_chg_next;
    logic [TICK_W-1:0]  since_rep_reg,  since_rep_next;
    logic [SUM_W-1:0]   last_total_reg, last_total_next;

    logic               out_valid_reg;
    out_item_t          out_data_reg,   out_data_next;

    logic               in_xfer;
    logic [ACC_W-1:0]   acc_sum;
    logic [SUM_W-1:0]   group_total;
    logic               group_end;
    logic               day;
    logic               want;
    logic [TICK_W-1:0]  chg_inc;
    logic [TICK_W-1:0]  rep_inc;
    logic [EVT_W-1:0]   sw_evt;
    logic [EVT_W-1:0]   rep_evt;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            critical_sum_reg    <= CRITICAL_SUM_RST;
            recovery_sum_reg    <= RECOVERY_SUM_RST;
            daylight_level_reg  <= DAYLIGHT_LEVEL_RST;
            cooldown_ticks_reg  <= COOLDOWN_TICKS_RST;
            report_interval_reg <= REPORT_INTERVAL_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_CRITICAL_SUM:    critical_sum_reg    <= cfg_data[SUM_W-1:0];
                CFG_RECOVERY_SUM:    recovery_sum_reg    <= cfg_data[SUM_W-1:0];
                CFG_DAYLIGHT_LEVEL:  daylight_level_reg  <= cfg_data[LIGHT_W-1:0];
                CFG_COOLDOWN_TICKS:  cooldown_ticks_reg  <= cfg_data[TICK_W-1:0];
                CFG_REPORT_INTERVAL: report_interval_reg <= cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        chg_inc = (since_chg_reg == TICK_MAX) ? TICK_MAX : since_chg_reg + 1'b1;
        rep_inc = (since_rep_reg == TICK_MAX) ? TICK_MAX : since_rep_reg + 1'b1;

        acc_sum = acc_reg + ACC_W'(in_data.battery_sample);
        if (acc_sum > ACC_W'(SUM_MAX))
            group_total = SUM_MAX;
        else
            group_total = acc_sum[SUM_W-1:0];

        group_end = (cnt_reg == CNT_LAST);
        day       = in_data.light_sample > daylight_level_reg;

        // middle band: night forces off, day holds
        priority if (group_total < critical_sum_reg)
            want = 1'b0;
        else if (group_total > recovery_sum_reg)
            want = day;
        else
            want = day && load_on_reg;

        acc_next        = acc_sum;
        cnt_next        = cnt_reg + 1'b1;
        load_on_next    = load_on_reg;
        since_chg_next  = chg_inc;
        since_rep_next  = rep_inc;
        last_total_next = last_total_reg;
        sw_evt          = SW_NONE;
        rep_evt         = REP_NONE;

        if (group_end)
        begin
            acc_next        = '0;
            cnt_next        = '0;
            last_total_next = group_total;

            if (want != load_on_reg)
            begin
                if (chg_inc > cooldown_ticks_reg)
                begin
                    load_on_next   = want;
                    since_chg_next = '0;
                    sw_evt         = want ? SW_ON : SW_OFF;
                end
                else
                begin
                    sw_evt = SW_BLOCKED;
                end
            end

            // report uses the load state from before this decision
            if (rep_inc >= report_interval_reg)
            begin
                since_rep_next = '0;
                rep_evt        = load_on_reg ? REP_DUE : REP_SKIPPED;
            end
        end

        out_data_next.load_enable   = load_on_next;
        out_data_next.evaluated     = group_end;
        out_data_next.battery_total = last_total_next;
        out_data_next.switch_event  = sw_evt;
        out_data_next.report_event  = rep_evt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            cnt_reg        <= '0;
            load_on_reg    <= 1'b1;
            since_chg_reg  <= '0;
            since_rep_reg  <= '0;
            last_total_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                acc_reg        <= acc_next;
                cnt_reg        <= cnt_next;
                load_on_reg    <= load_on_next;
                since_chg_reg  <= since_chg_next;
                since_rep_reg  <= since_rep_next;
                last_total_reg <= last_total_next;
                out_valid_reg  <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded on each input transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    a_sw_on_level: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.switch_event == SW_ON) |-> out_data.load_enable)
        else $error("switched on but load disabled");

    a_sw_off_level: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.switch_event == SW_OFF) |-> !out_data.load_enable)
        else $error("switched off but load enabled");

    a_events_at_group_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.evaluated) |->
            (out_data.switch_event == SW_NONE && out_data.report_event == REP_NONE))
        else $error("event flagged outside a group end");

    a_count_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && cnt_reg != CNT_LAST) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("sample count did not advance on transfer");
`endif

endmodule

`default_nettype wire
